// File: design/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared definitions for the cost token bucket throttle
// Command codes, update mask bits, register indexes, sequencer types and the
// control and status structs that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctb_pkg;

   // Default widths of the cost and rate fields.
   localparam int unsigned COST_BITS_DEF = 20;
   localparam int unsigned RATE_BITS_DEF = 16;

   // Headroom bits for a value in millipoints (1000 < 2**10).
   localparam int unsigned MILLI_SHIFT = 10;

   // Width of the delay and level fields of a result beat.
   localparam int unsigned OUT_LEVEL_BITS = 30;

   // Width of the command selector.
   localparam int unsigned CMD_BITS = 3;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_RESERVE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_UPDATE  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_RELOAD  = 3'd4;

   // Present mask of a server update.
   localparam int unsigned MASK_BITS      = 5;
   localparam int unsigned MASK_REQUESTED = 0;
   localparam int unsigned MASK_ACTUAL    = 1;
   localparam int unsigned MASK_MAXIMUM   = 2;
   localparam int unsigned MASK_AVAILABLE = 3;
   localparam int unsigned MASK_RATE      = 4;

   // Configuration port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CFG_MAXIMUM_W = 20;
   localparam int unsigned CFG_RATE_W = 16;
   localparam logic CSR_IDX_RESET_MAXIMUM = 1'b0;
   localparam logic CSR_IDX_RESET_RATE    = 1'b1;
   localparam logic [CFG_MAXIMUM_W-1:0] RESET_MAXIMUM_DEF = 20'd1000;
   localparam logic [CFG_RATE_W-1:0]    RESET_RATE_DEF    = 16'd50;

   // Shared arithmetic unit operation.
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SCALE_AVAIL,
      ST_ALU1,
      ST_ALU2,
      ST_DIVIDE,
      ST_EMIT
   } seq_state_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic                start;
      logic [CMD_BITS-1:0] cmd;
      logic                avail_present;
      logic                div_last;
      logic                out_free;
   } seq_status_type;

   // Step enables driven by the sequencer.
   typedef struct packed {
      logic in_ready;
      logic scale;
      logic scale_avail;
      logic alu1;
      logic alu2;
      logic divide;
      logic emit;
   } seq_ctrl_type;

endpackage

// File: design/ctb_alu.sv
// ----------------------------------------------------------------------------
// ctb_alu: shared add/subtract unit
// One adder serves every add, compare and division step of the throttle.
// On a subtract, below flags that the first operand is less than the second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctb_alu #(
   parameter int unsigned WIDTH = ctb_pkg::COST_BITS_DEF + ctb_pkg::MILLI_SHIFT + 1
) (
   input  ctb_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    opa,
   input  logic [WIDTH-1:0]    opb,
   output logic [WIDTH-1:0]    result,
   output logic                below
);

   logic             sub;
   logic [WIDTH-1:0] opb_eff;
   logic [WIDTH:0]   total;

   // A subtract is an add of the inverted operand with a carry in.
   assign sub     = (op == ctb_pkg::ALU_SUB);
   assign opb_eff = sub ? ~opb : opb;
   assign total   = {1'b0, opa} + {1'b0, opb_eff} + {{WIDTH{1'b0}}, sub};

   assign result = total[WIDTH-1:0];
   assign below  = sub & ~total[WIDTH];

endmodule

// File: design/ctb_seq.sv
// ----------------------------------------------------------------------------
// ctb_seq: step sequencer
// Walks one command through scaling, up to two arithmetic steps, the
// bit-serial division of a delay query and the hand-off to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctb_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  ctb_pkg::seq_status_type status,
   output ctb_pkg::seq_ctrl_type   ctrl
);

   ctb_pkg::seq_state_type state_ff;
   ctb_pkg::seq_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctb_pkg::ST_IDLE: begin
            if (status.start) state_in = ctb_pkg::ST_SCALE;
         end
         ctb_pkg::ST_SCALE: begin
            case (status.cmd)
               ctb_pkg::CMD_TICK,
               ctb_pkg::CMD_RESERVE,
               ctb_pkg::CMD_QUERY: state_in = ctb_pkg::ST_ALU1;
               ctb_pkg::CMD_UPDATE: begin
                  state_in = status.avail_present ? ctb_pkg::ST_SCALE_AVAIL
                                                  : ctb_pkg::ST_ALU1;
               end
               default: state_in = ctb_pkg::ST_EMIT;
            endcase
         end
         ctb_pkg::ST_SCALE_AVAIL: state_in = ctb_pkg::ST_ALU1;
         ctb_pkg::ST_ALU1: begin
            if (status.cmd == ctb_pkg::CMD_TICK || status.cmd == ctb_pkg::CMD_QUERY) begin
               state_in = ctb_pkg::ST_ALU2;
            end else begin
               state_in = ctb_pkg::ST_EMIT;
            end
         end
         ctb_pkg::ST_ALU2: begin
            state_in = (status.cmd == ctb_pkg::CMD_QUERY) ? ctb_pkg::ST_DIVIDE
                                                          : ctb_pkg::ST_EMIT;
         end
         ctb_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = ctb_pkg::ST_EMIT;
         end
         ctb_pkg::ST_EMIT: begin
            if (status.out_free) state_in = ctb_pkg::ST_IDLE;
         end
         default: state_in = ctb_pkg::ST_IDLE;
      endcase
   end

   // Step enables.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ctb_pkg::ST_IDLE:        ctrl.in_ready    = 1'b1;
         ctb_pkg::ST_SCALE:       ctrl.scale       = 1'b1;
         ctb_pkg::ST_SCALE_AVAIL: ctrl.scale_avail = 1'b1;
         ctb_pkg::ST_ALU1:        ctrl.alu1        = 1'b1;
         ctb_pkg::ST_ALU2:        ctrl.alu2        = 1'b1;
         ctb_pkg::ST_DIVIDE:      ctrl.divide      = 1'b1;
         ctb_pkg::ST_EMIT:        ctrl.emit        = 1'b1;
         default:                 ctrl             = '0;
      endcase
   end

endmodule

// File: design/ctb_csr.sv
// ----------------------------------------------------------------------------
// ctb_csr: configuration registers
// Holds the capacity and restore rate registers, reset to the package
// defaults, behind a two-phase register port that is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ctb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ctb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ctb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic [ctb_pkg::CFG_MAXIMUM_W-1:0] reset_maximum_ff;
   logic [ctb_pkg::CFG_RATE_W-1:0]    reset_rate_ff;
   logic                              wr_en;
   logic                              reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   // Register writes in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_maximum_ff <= ctb_pkg::RESET_MAXIMUM_DEF;
         reset_rate_ff    <= ctb_pkg::RESET_RATE_DEF;
      end else if (wr_en) begin
         case (reg_idx)
            ctb_pkg::CSR_IDX_RESET_MAXIMUM:
               reset_maximum_ff <= pwdata[ctb_pkg::CFG_MAXIMUM_W-1:0];
            ctb_pkg::CSR_IDX_RESET_RATE:
               reset_rate_ff <= pwdata[ctb_pkg::CFG_RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         ctb_pkg::CSR_IDX_RESET_MAXIMUM: prdata = ctb_pkg::CSR_DATA_W'(reset_maximum_ff);
         ctb_pkg::CSR_IDX_RESET_RATE:    prdata = ctb_pkg::CSR_DATA_W'(reset_rate_ff);
         default:                        prdata = '0;
      endcase
   end

endmodule

// File: design/cost_token_bucket_throttle.sv
// ----------------------------------------------------------------------------
// cost_token_bucket_throttle: token bucket for query cost credit
// Reload and unknown commands pass the scale and emit steps only; reserve and
// an update without a level add one arithmetic step, a tick two, and an update
// with a level the level scale and one arithmetic step. A delay query adds two
// arithmetic steps and a division, one quotient bit a cycle on the shared adder.
// A stalled result beat holds the next accept.
// Synchronous reset loads capacity 1000, rate 50 and a full bucket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cost_token_bucket_throttle #(
   parameter int unsigned COST_BITS = ctb_pkg::COST_BITS_DEF,
   parameter int unsigned RATE_BITS = ctb_pkg::RATE_BITS_DEF,
   localparam int unsigned REQ_W = ((5 * COST_BITS + RATE_BITS + ctb_pkg::MASK_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W =
      ((2 * ctb_pkg::OUT_LEVEL_BITS + 3 * COST_BITS + RATE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cost, rate, report_requested, report_actual, report_maximum,
   // report_available, present_mask
   input  logic [REQ_W-1:0]                    req_tdata,
   // cmd
   input  logic [ctb_pkg::CMD_BITS-1:0]        req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // delay_ms, available_milli, maximum_now, rate_now, last_requested,
   // last_actual
   output logic [RSP_W-1:0]                    rsp_tdata,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ctb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ctb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ctb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned LEVEL_W = COST_BITS + ctb_pkg::MILLI_SHIFT;
   localparam int unsigned ACC_W   = LEVEL_W + 1;
   localparam int unsigned ALU_W   = (ACC_W > RATE_BITS + 1) ? ACC_W : RATE_BITS + 1;
   localparam int unsigned CNT_W   = $clog2(ACC_W);
   localparam int unsigned OUT_W   = ctb_pkg::OUT_LEVEL_BITS;

   // Request field offsets.
   localparam int unsigned OFF_COST  = 0;
   localparam int unsigned OFF_RATE  = COST_BITS;
   localparam int unsigned OFF_REQ   = COST_BITS + RATE_BITS;
   localparam int unsigned OFF_ACT   = 2 * COST_BITS + RATE_BITS;
   localparam int unsigned OFF_MAX   = 3 * COST_BITS + RATE_BITS;
   localparam int unsigned OFF_AVAIL = 4 * COST_BITS + RATE_BITS;
   localparam int unsigned OFF_MASK  = 5 * COST_BITS + RATE_BITS;

   // Response field offsets.
   localparam int unsigned OFF_DELAY    = 0;
   localparam int unsigned OFF_LEVEL    = OUT_W;
   localparam int unsigned OFF_MAX_NOW  = 2 * OUT_W;
   localparam int unsigned OFF_RATE_NOW = 2 * OUT_W + COST_BITS;
   localparam int unsigned OFF_LAST_REQ = 2 * OUT_W + COST_BITS + RATE_BITS;
   localparam int unsigned OFF_LAST_ACT = 2 * OUT_W + 2 * COST_BITS + RATE_BITS;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

   // Zero is taken as one for capacity and rate.
   function automatic logic [COST_BITS-1:0] floor_one_cost(input logic [COST_BITS-1:0] v);
      floor_one_cost = (v == '0) ? COST_BITS'(1) : v;
   endfunction

   function automatic logic [RATE_BITS-1:0] floor_one_rate(input logic [RATE_BITS-1:0] v);
      floor_one_rate = (v == '0) ? RATE_BITS'(1) : v;
   endfunction

   // Points to millipoints: x * 1000 = x * 1024 - x * 16 - x * 8.
   function automatic logic [LEVEL_W-1:0] scale_milli(input logic [COST_BITS-1:0] x);
      logic [LEVEL_W-1:0] x_ext;
      x_ext = LEVEL_W'(x);
      scale_milli = (x_ext << 10) - (x_ext << 4) - (x_ext << 3);
   endfunction

   localparam logic [COST_BITS-1:0] CAP_RST =
      floor_one_cost(COST_BITS'(ctb_pkg::RESET_MAXIMUM_DEF));
   localparam logic [RATE_BITS-1:0] RATE_RST =
      floor_one_rate(RATE_BITS'(ctb_pkg::RESET_RATE_DEF));

   ctb_pkg::seq_status_type status;
   ctb_pkg::seq_ctrl_type   ctrl;

   // Captured request beat.
   logic [ctb_pkg::CMD_BITS-1:0]  cmd_ff;
   logic [COST_BITS-1:0]          cost_ff;
   logic [RATE_BITS-1:0]          rate_arg_ff;
   logic [COST_BITS-1:0]          rep_req_ff;
   logic [COST_BITS-1:0]          rep_act_ff;
   logic [COST_BITS-1:0]          rep_max_ff;
   logic [COST_BITS-1:0]          rep_avail_ff;
   logic [ctb_pkg::MASK_BITS-1:0] mask_ff;

   // Bucket state.
   logic [LEVEL_W-1:0]   level_ff,    level_in;
   logic [COST_BITS-1:0] cap_ff,      cap_in;
   logic [RATE_BITS-1:0] rate_ff,     rate_in;
   logic [COST_BITS-1:0] req_cost_ff, req_cost_in;
   logic [COST_BITS-1:0] act_cost_ff, act_cost_in;

   // Working registers.
   logic [LEVEL_W-1:0]   tmp_ff, tmp_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [RATE_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff,  rsp_data_in;
   logic [RSP_W-1:0] rsp_pack;

   // Shared unit and scaler.
   ctb_pkg::alu_op_type  alu_op;
   logic [ALU_W-1:0]     alu_a;
   logic [ALU_W-1:0]     alu_b;
   logic [ALU_W-1:0]     alu_sum;
   logic                 alu_below;
   logic [COST_BITS-1:0] scale_src;
   logic [LEVEL_W-1:0]   scaled;
   logic [COST_BITS-1:0] cap_upd;
   logic [COST_BITS-1:0] cost_floor;
   logic [RATE_BITS:0]   div_partial;
   logic [RATE_BITS-1:0] rate_dec;
   logic                 accept;
   logic                 out_free;

   ctb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   ctb_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_sum),
      .below  (alu_below)
   );

   ctb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   // Handshakes.
   assign req_tready = ctrl.in_ready & ~reset;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.start         = accept;
   assign status.cmd           = cmd_ff;
   assign status.avail_present = mask_ff[ctb_pkg::MASK_AVAILABLE];
   assign status.div_last      = (cnt_ff == DIV_LAST);
   assign status.out_free      = out_free;

   // Derived operands.
   assign cap_upd     = mask_ff[ctb_pkg::MASK_MAXIMUM] ? floor_one_cost(rep_max_ff) : cap_ff;
   assign cost_floor  = floor_one_cost(cost_ff);
   assign div_partial = {rem_ff, acc_ff[ACC_W-1]};
   assign rate_dec    = rate_ff - RATE_BITS'(1);

   // Scaler source: capacity, cost or reported level, by step and command.
   always_comb begin
      scale_src = cap_ff;
      if (ctrl.scale_avail) begin
         scale_src = rep_avail_ff;
      end else begin
         case (cmd_ff)
            ctb_pkg::CMD_RESERVE,
            ctb_pkg::CMD_QUERY:  scale_src = cost_ff;
            ctb_pkg::CMD_UPDATE: scale_src = cap_upd;
            ctb_pkg::CMD_RELOAD: scale_src = cost_floor;
            default:             scale_src = cap_ff;
         endcase
      end
   end

   assign scaled = scale_milli(scale_src);

   // Operand selection for the shared unit.
   always_comb begin
      alu_op = ctb_pkg::ALU_SUB;
      alu_a  = '0;
      alu_b  = '0;
      if (ctrl.alu1) begin
         case (cmd_ff)
            ctb_pkg::CMD_TICK: begin
               alu_op = ctb_pkg::ALU_ADD;
               alu_a  = ALU_W'(level_ff);
               alu_b  = ALU_W'(rate_ff);
            end
            ctb_pkg::CMD_QUERY: begin
               alu_a = ALU_W'(tmp_ff);
               alu_b = ALU_W'(level_ff);
            end
            default: begin
               alu_a = ALU_W'(level_ff);
               alu_b = ALU_W'(tmp_ff);
            end
         endcase
      end else if (ctrl.alu2) begin
         if (cmd_ff == ctb_pkg::CMD_QUERY) begin
            alu_op = ctb_pkg::ALU_ADD;
            alu_a  = ALU_W'(acc_ff);
            alu_b  = ALU_W'(rate_dec);
         end else begin
            alu_a = ALU_W'(acc_ff);
            alu_b = ALU_W'(tmp_ff);
         end
      end else if (ctrl.divide) begin
         alu_a = ALU_W'(div_partial);
         alu_b = ALU_W'(rate_ff);
      end
   end

   // Next values of the bucket and working registers.
   always_comb begin
      level_in    = level_ff;
      cap_in      = cap_ff;
      rate_in     = rate_ff;
      req_cost_in = req_cost_ff;
      act_cost_in = act_cost_ff;
      tmp_in      = tmp_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;

      // Scale step: the value in millipoints and the plain field updates.
      if (ctrl.scale) begin
         tmp_in = scaled;
         case (cmd_ff)
            ctb_pkg::CMD_RESERVE: req_cost_in = cost_ff;
            ctb_pkg::CMD_UPDATE: begin
               if (mask_ff[ctb_pkg::MASK_REQUESTED]) req_cost_in = rep_req_ff;
               if (mask_ff[ctb_pkg::MASK_ACTUAL])    act_cost_in = rep_act_ff;
               if (mask_ff[ctb_pkg::MASK_RATE])      rate_in     = floor_one_rate(rate_arg_ff);
               cap_in = cap_upd;
            end
            ctb_pkg::CMD_RELOAD: begin
               cap_in      = cost_floor;
               level_in    = scaled;
               rate_in     = floor_one_rate(rate_arg_ff);
               req_cost_in = '0;
               act_cost_in = '0;
            end
            default: ;
         endcase
      end

      // Reported level, clamped to capacity in the next step.
      if (ctrl.scale_avail) begin
         level_in = scaled;
      end

      // First arithmetic step.
      if (ctrl.alu1) begin
         case (cmd_ff)
            ctb_pkg::CMD_TICK: acc_in = ACC_W'(alu_sum);
            ctb_pkg::CMD_RESERVE: begin
               level_in = alu_below ? '0 : LEVEL_W'(alu_sum);
            end
            ctb_pkg::CMD_QUERY: begin
               acc_in = alu_below ? '0 : ACC_W'(alu_sum);
            end
            ctb_pkg::CMD_UPDATE: begin
               if (!alu_below) level_in = tmp_ff;
            end
            default: ;
         endcase
      end

      // Second step: clamp a tick, or round the deficit up before dividing.
      if (ctrl.alu2) begin
         if (cmd_ff == ctb_pkg::CMD_QUERY) begin
            acc_in = ACC_W'(alu_sum);
            rem_in = '0;
            cnt_in = '0;
         end else begin
            level_in = alu_below ? LEVEL_W'(acc_ff) : tmp_ff;
         end
      end

      // Restoring division, one quotient bit per cycle.
      if (ctrl.divide) begin
         rem_in = alu_below ? RATE_BITS'(div_partial) : RATE_BITS'(alu_sum);
         acc_in = {acc_ff[ACC_W-2:0], ~alu_below};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Result beat packing.
   always_comb begin
      rsp_pack = '0;
      rsp_pack[OFF_DELAY +: OUT_W] = (cmd_ff == ctb_pkg::CMD_QUERY) ? OUT_W'(acc_ff) : '0;
      rsp_pack[OFF_LEVEL +: OUT_W] = OUT_W'(level_ff);
      rsp_pack[OFF_MAX_NOW +: COST_BITS]  = cap_ff;
      rsp_pack[OFF_RATE_NOW +: RATE_BITS] = rate_ff;
      rsp_pack[OFF_LAST_REQ +: COST_BITS] = req_cost_ff;
      rsp_pack[OFF_LAST_ACT +: COST_BITS] = act_cost_ff;
   end

   // Output register: loaded in the emit step, freed when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_pack;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and bucket state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         level_ff     <= scale_milli(CAP_RST);
         cap_ff       <= CAP_RST;
         rate_ff      <= RATE_RST;
         req_cost_ff  <= '0;
         act_cost_ff  <= '0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         cap_ff       <= cap_in;
         rate_ff      <= rate_in;
         req_cost_ff  <= req_cost_in;
         act_cost_ff  <= act_cost_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_tuser;
         cost_ff      <= req_tdata[OFF_COST +: COST_BITS];
         rate_arg_ff  <= req_tdata[OFF_RATE +: RATE_BITS];
         rep_req_ff   <= req_tdata[OFF_REQ +: COST_BITS];
         rep_act_ff   <= req_tdata[OFF_ACT +: COST_BITS];
         rep_max_ff   <= req_tdata[OFF_MAX +: COST_BITS];
         rep_avail_ff <= req_tdata[OFF_AVAIL +: COST_BITS];
         mask_ff      <= req_tdata[OFF_MASK +: ctb_pkg::MASK_BITS];
      end
      tmp_ff      <= tmp_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/ctb_checker.sv
// ----------------------------------------------------------------------------
// ctb_checker: port-level checks for the throttle
// Watches the request and response channels of the top level and is
// attached to it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctb_checker #(
   parameter int unsigned COST_BITS = ctb_pkg::COST_BITS_DEF,
   parameter int unsigned RATE_BITS = ctb_pkg::RATE_BITS_DEF,
   localparam int unsigned RSP_W =
      ((2 * ctb_pkg::OUT_LEVEL_BITS + 3 * COST_BITS + RATE_BITS + 7) / 8) * 8
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [RSP_W-1:0]               rsp_tdata
);

   localparam int unsigned OFF_MAX_NOW  = 2 * ctb_pkg::OUT_LEVEL_BITS;
   localparam int unsigned OFF_RATE_NOW = 2 * ctb_pkg::OUT_LEVEL_BITS + COST_BITS;

   logic [COST_BITS-1:0] max_now;
   logic [RATE_BITS-1:0] rate_now;

   assign max_now  = rsp_tdata[OFF_MAX_NOW +: COST_BITS];
   assign rate_now = rsp_tdata[OFF_RATE_NOW +: RATE_BITS];

   // The block works on one item at a time: no beat is taken right after one.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous item is in progress");

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // Capacity and rate never drop below one in any result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (max_now != '0 && rate_now != '0))
      else $error("result shows zero capacity or rate");

endmodule

bind cost_token_bucket_throttle ctb_checker #(
   .COST_BITS (COST_BITS),
   .RATE_BITS (RATE_BITS)
) u_ctb_checker (.*);

// File: tb/sv/cost_token_bucket_throttle_checker.sv
// ----------------------------------------------------------------------------
// cost_token_bucket_throttle_checker: bucket predictor and result scoreboard
// Watches the request, response and configuration ports of the throttle.
// Every accepted request beat is run through a local copy of the bucket state
// and the predicted snapshot is queued. Every accepted response beat is
// compared field by field with the oldest queued snapshot. Register reads are
// checked against the last value written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cost_token_bucket_throttle_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [127:0]                      req_tdata,
   input  logic [ctb_pkg::CMD_BITS-1:0]      req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [135:0]                      rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ctb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ctb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic [ctb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  logic                              csr_pready,
   output int unsigned                       failures,
   output int unsigned                       pending_results
);

   import ctb_pkg::*;

   localparam int unsigned CB = COST_BITS_DEF;
   localparam int unsigned RB = RATE_BITS_DEF;
   localparam int unsigned LB = OUT_LEVEL_BITS;
   localparam int unsigned REQ_FIELD_BITS = 5 * CB + RB + MASK_BITS;
   localparam int unsigned REQ_W = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam longint unsigned MILLI_PER_POINT = 1000;

   // Request beat fields, lowest bits last.
   typedef struct packed {
      logic [REQ_W-REQ_FIELD_BITS-1:0] spare;
      logic [MASK_BITS-1:0]            present_mask;
      logic [CB-1:0]                   report_available;
      logic [CB-1:0]                   report_maximum;
      logic [CB-1:0]                   report_actual;
      logic [CB-1:0]                   report_requested;
      logic [RB-1:0]                   rate;
      logic [CB-1:0]                   cost;
   } bucket_request_t;

   // Response beat fields, lowest bits last.
   typedef struct packed {
      logic [CB-1:0] last_actual;
      logic [CB-1:0] last_requested;
      logic [RB-1:0] rate_now;
      logic [CB-1:0] maximum_now;
      logic [LB-1:0] available_milli;
      logic [LB-1:0] delay_ms;
   } bucket_snapshot_t;

   // Configuration registers and the predicted bucket state.
   logic [CFG_MAXIMUM_W-1:0] reset_maximum_reg;
   logic [CFG_RATE_W-1:0]    reset_rate_reg;
   longint unsigned          level_milli;
   logic [CB-1:0]            capacity_pts;
   logic [RB-1:0]            refill_pps;
   logic [CB-1:0]            requested_pts;
   logic [CB-1:0]            actual_pts;

   bucket_snapshot_t expected_snapshots[$];

   initial begin
      failures = 0;
      pending_results = 0;
   end

   // Applies one command to the bucket and returns the snapshot it reports.
   function automatic bucket_snapshot_t advance_bucket(input logic [CMD_BITS-1:0] cmd,
                                                       input bucket_request_t rq);
      longint unsigned top_milli;
      longint unsigned need_milli;
      longint unsigned deficit;
      longint unsigned delay;
      logic [CB-1:0]   avail_pts;
      bucket_snapshot_t snap;
      delay = 0;
      case (cmd)
         CMD_TICK: begin
            top_milli = capacity_pts * MILLI_PER_POINT;
            level_milli = level_milli + refill_pps;
            if (level_milli > top_milli) level_milli = top_milli;
         end
         CMD_RESERVE: begin
            need_milli = rq.cost * MILLI_PER_POINT;
            requested_pts = rq.cost;
            level_milli = (need_milli >= level_milli) ? 0 : level_milli - need_milli;
         end
         CMD_QUERY: begin
            // Round the wait up so that the full deficit is covered.
            need_milli = rq.cost * MILLI_PER_POINT;
            deficit = (need_milli > level_milli) ? need_milli - level_milli : 0;
            delay = (deficit + refill_pps - 1) / refill_pps;
         end
         CMD_UPDATE: begin
            if (rq.present_mask[MASK_REQUESTED]) requested_pts = rq.report_requested;
            if (rq.present_mask[MASK_ACTUAL]) actual_pts = rq.report_actual;
            if (rq.present_mask[MASK_MAXIMUM]) begin
               capacity_pts = (rq.report_maximum == '0) ? 1 : rq.report_maximum;
            end
            top_milli = capacity_pts * MILLI_PER_POINT;
            // A reported level is clamped to the capacity; otherwise the old
            // level is clamped to a capacity that may have shrunk.
            if (rq.present_mask[MASK_AVAILABLE]) begin
               avail_pts = (rq.report_available > capacity_pts) ? capacity_pts
                                                                 : rq.report_available;
               level_milli = avail_pts * MILLI_PER_POINT;
            end else if (level_milli > top_milli) begin
               level_milli = top_milli;
            end
            if (rq.present_mask[MASK_RATE]) refill_pps = (rq.rate == '0) ? 1 : rq.rate;
         end
         CMD_RELOAD: begin
            capacity_pts = (rq.cost == '0) ? 1 : rq.cost;
            level_milli = capacity_pts * MILLI_PER_POINT;
            refill_pps = (rq.rate == '0) ? 1 : rq.rate;
            requested_pts = '0;
            actual_pts = '0;
         end
         default: begin
            // Unknown commands leave the state alone.
         end
      endcase
      snap.delay_ms = delay[LB-1:0];
      snap.available_milli = level_milli[LB-1:0];
      snap.maximum_now = capacity_pts;
      snap.rate_now = refill_pps;
      snap.last_requested = requested_pts;
      snap.last_actual = actual_pts;
      return snap;
   endfunction

   // Reports one field that differs and returns the number of mismatches.
   function automatic int unsigned field_mismatch(input string name, input logic [31:0] want,
                                                  input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Monitor all three ports at each rising edge.
   always @(posedge clock) begin : monitor
      bucket_snapshot_t want;
      bucket_snapshot_t got;
      logic [31:0]      reg_value;
      if (reset) begin
         reset_maximum_reg = RESET_MAXIMUM_DEF;
         reset_rate_reg = RESET_RATE_DEF;
         capacity_pts = (reset_maximum_reg == '0) ? 1 : reset_maximum_reg;
         refill_pps = (reset_rate_reg == '0) ? 1 : reset_rate_reg;
         level_milli = capacity_pts * MILLI_PER_POINT;
         requested_pts = '0;
         actual_pts = '0;
         expected_snapshots.delete();
      end else begin
         // Response beat against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got = bucket_snapshot_t'(rsp_tdata);
            if (expected_snapshots.size() == 0) begin
               $error("response beat arrived with no prediction waiting");
               failures = failures + 1;
            end else begin
               want = expected_snapshots.pop_front();
               failures = failures
                  + field_mismatch("delay_ms", want.delay_ms, got.delay_ms)
                  + field_mismatch("available_milli", want.available_milli,
                                   got.available_milli)
                  + field_mismatch("maximum_now", want.maximum_now, got.maximum_now)
                  + field_mismatch("rate_now", want.rate_now, got.rate_now)
                  + field_mismatch("last_requested", want.last_requested,
                                   got.last_requested)
                  + field_mismatch("last_actual", want.last_actual, got.last_actual);
            end
         end

         // Request beat: predict its snapshot.
         if (req_tvalid && req_tready) begin
            expected_snapshots.push_back(advance_bucket(req_tuser,
                                                        bucket_request_t'(req_tdata)));
         end

         // Register access phase: track writes, check reads.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_RESET_MAXIMUM) begin
                  reset_maximum_reg = csr_pwdata[CFG_MAXIMUM_W-1:0];
               end else begin
                  reset_rate_reg = csr_pwdata[CFG_RATE_W-1:0];
               end
            end else begin
               if (csr_paddr[2] == CSR_IDX_RESET_MAXIMUM) begin
                  reg_value = 32'(reset_maximum_reg);
                  failures = failures + field_mismatch("reset_maximum", reg_value, csr_prdata);
               end else begin
                  reg_value = 32'(reset_rate_reg);
                  failures = failures + field_mismatch("reset_rate", reg_value, csr_prdata);
               end
            end
         end
      end
      pending_results = expected_snapshots.size();
   end

endmodule

// File: tb/sv/cost_token_bucket_throttle_test.sv
// ----------------------------------------------------------------------------
// cost_token_bucket_throttle_test: stimulus and verdict for the bucket throttle
// Resets the block once, checks the register reset values, runs a directed
// pass over the field extremes, every command and the clamping corner cases,
// then four random phases with different register settings. Both stream
// sides idle at random; the receiver once holds off long enough to back the
// block up. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cost_token_bucket_throttle_test;

   import ctb_pkg::*;

   localparam int unsigned CB = COST_BITS_DEF;
   localparam int unsigned RB = RATE_BITS_DEF;
   localparam int unsigned REQ_W = ((5 * CB + RB + MASK_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_W = ((2 * OUT_LEVEL_BITS + 3 * CB + RB + 7) / 8) * 8;
   localparam time         CLOCK_PERIOD = 20ns;
   localparam int unsigned GAP_MAX = 12;
   localparam int unsigned HOLD_AFTER = 300;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned ITEMS_PER_PHASE = 250;
   localparam logic [CMD_BITS-1:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_UNKNOWN_HI = 3'd7;
   localparam logic [CB-1:0] COST_FULL = '1;
   localparam logic [RB-1:0] RATE_FULL = '1;
   localparam logic [MASK_BITS-1:0] MASK_NONE = '0;
   localparam logic [MASK_BITS-1:0] MASK_ALL = '1;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [CMD_BITS-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int unsigned failures;
   int unsigned pending_results;
   int unsigned quiet_cycles = 0;
   bit sender_eager = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   cost_token_bucket_throttle dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cost_token_bucket_throttle_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .failures        (failures),
      .pending_results (pending_results)
   );

   // Watchdog: end the run if no beat or register access completes for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register access; called at a falling edge and returns at one.
   task automatic csr_access(input bit write, input logic idx, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offers one request beat after a random gap and waits for its acceptance.
   task automatic send_beat(input logic [CMD_BITS-1:0] cmd, input logic [CB-1:0] cost,
                            input logic [RB-1:0] rate, input logic [CB-1:0] rep_req,
                            input logic [CB-1:0] rep_act, input logic [CB-1:0] rep_max,
                            input logic [CB-1:0] rep_avail, input logic [MASK_BITS-1:0] mask);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) sender_eager = !sender_eager;
      gap = sender_eager ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= REQ_W'({mask, rep_avail, rep_max, rep_act, rep_req, rate, cost});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Points value biased toward the extremes and toward small costs.
   function automatic logic [CB-1:0] pick_points();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COST_FULL;
         2, 3, 4: return CB'($urandom_range(0, 2000));
         default: return CB'($urandom);
      endcase
   endfunction

   function automatic logic [RB-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return RATE_FULL;
         2, 3: return RB'($urandom_range(1, 100));
         default: return RB'($urandom);
      endcase
   endfunction

   // Random command mix, weighted toward ticks, reserves and queries.
   task automatic send_random_item();
      logic [CMD_BITS-1:0] cmd;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_TICK;
      else if (pick < 50) cmd = CMD_RESERVE;
      else if (pick < 72) cmd = CMD_QUERY;
      else if (pick < 88) cmd = CMD_UPDATE;
      else if (pick < 94) cmd = CMD_RELOAD;
      else cmd = CMD_BITS'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      send_beat(cmd, pick_points(), pick_rate(), pick_points(), pick_points(),
                pick_points(), pick_points(), MASK_BITS'($urandom_range(0, 31)));
   endtask

   // Waits until every predicted result has come back, then lets the block go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Response side: random stalls, eager stretches and one long hold-off.
   initial begin : result_sink
      int unsigned gap;
      int unsigned taken;
      bit eager;
      bit held;
      rsp_tready = 1'b0;
      taken = 0;
      eager = 1'b0;
      held = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) eager = !eager;
         gap = eager ? 0 : $urandom_range(0, GAP_MAX);
         if (!held && taken == HOLD_AFTER) begin
            held = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken = taken + 1;
         @(negedge clock);
      end
   end

   // Request side and verdict.
   initial begin : stimulus
      logic [CFG_MAXIMUM_W-1:0] max_setting;
      logic [CFG_RATE_W-1:0]    rate_setting;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_TICK;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register reset values.
      csr_access(1'b0, CSR_IDX_RESET_MAXIMUM, '0);
      csr_access(1'b0, CSR_IDX_RESET_RATE, '0);

      // Directed: queries against a full and a partly drained bucket.
      send_beat(CMD_QUERY, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_QUERY, COST_FULL, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RESERVE, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RESERVE, 20'd400, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_QUERY, 20'd1000, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_TICK, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_TICK, COST_FULL, RATE_FULL, COST_FULL, COST_FULL, COST_FULL,
                COST_FULL, MASK_ALL);
      // A reserve larger than the level floors the bucket at zero.
      send_beat(CMD_RESERVE, COST_FULL, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_QUERY, 20'd1, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_TICK, '0, '0, '0, '0, '0, '0, MASK_NONE);
      // An update with no fields present changes nothing.
      send_beat(CMD_UPDATE, 20'd5, 16'd9, 20'd5, 20'd6, 20'd7, 20'd8, MASK_NONE);
      // Zero capacity and rate are raised to one; the level clamps to capacity.
      send_beat(CMD_UPDATE, '0, '0, COST_FULL, COST_FULL, '0, 20'd5, MASK_ALL);
      send_beat(CMD_QUERY, COST_FULL, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_TICK, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RELOAD, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RELOAD, COST_FULL, RATE_FULL, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_TICK, '0, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RESERVE, 20'd1, '0, '0, '0, '0, '0, MASK_NONE);
      // Shrinking capacity without a level clamps the old level.
      send_beat(CMD_UPDATE, '0, '0, '0, '0, 20'd10, '0, MASK_BITS'(1 << MASK_MAXIMUM));
      send_beat(CMD_UPDATE, '0, '0, '0, '0, '0, COST_FULL, MASK_BITS'(1 << MASK_AVAILABLE));
      send_beat(CMD_UPDATE, '0, RATE_FULL, '0, '0, '0, '0, MASK_BITS'(1 << MASK_RATE));
      // Unknown commands only report the snapshot.
      send_beat(CMD_UNKNOWN_LO, COST_FULL, RATE_FULL, COST_FULL, COST_FULL, COST_FULL,
                COST_FULL, MASK_ALL);
      send_beat(CMD_UNKNOWN_LO + 1'b1, 20'd3, 16'd3, '0, '0, '0, '0, MASK_ALL);
      send_beat(CMD_UNKNOWN_HI, COST_FULL, '0, '0, '0, '0, '0, MASK_NONE);
      send_beat(CMD_RELOAD, 20'd1000, 16'd50, '0, '0, '0, '0, MASK_NONE);
      settle();

      // Random phases, each with its own register setting.
      for (int unsigned phase = 1; phase <= RANDOM_PHASES; phase++) begin
         case (phase)
            1: begin
               max_setting = 20'd1;
               rate_setting = RATE_FULL;
            end
            2: begin
               max_setting = COST_FULL;
               rate_setting = 16'd1;
            end
            default: begin
               max_setting = CFG_MAXIMUM_W'($urandom_range(1, 2 ** CFG_MAXIMUM_W - 1));
               rate_setting = CFG_RATE_W'($urandom_range(1, 2 ** CFG_RATE_W - 1));
            end
         endcase
         csr_access(1'b1, CSR_IDX_RESET_MAXIMUM, 32'(max_setting));
         csr_access(1'b1, CSR_IDX_RESET_RATE, 32'(rate_setting));
         csr_access(1'b0, CSR_IDX_RESET_MAXIMUM, '0);
         csr_access(1'b0, CSR_IDX_RESET_RATE, '0);
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Once mid-run, let the block drain completely before going on.
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) settle();
            send_random_item();
         end
         settle();
      end

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ctb_pkg.sv
design/ctb_alu.sv
design/ctb_seq.sv
design/ctb_csr.sv
design/cost_token_bucket_throttle.sv
design/ctb_checker.sv
tb/sv/cost_token_bucket_throttle_checker.sv
tb/sv/cost_token_bucket_throttle_test.sv
